[rtl/apsc_pkg.sv]
// Shared types and constants for the audio packet sequence checker.
package apsc_pkg;

   // Configuration register indexes
   localparam int unsigned CsrIndexBits = 3;
   localparam int unsigned CsrDataBits  = 32;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_MAGIC_WORD       = 3'd0,
      CSR_PROTOCOL_VERSION = 3'd1,
      CSR_STOP_PACKET_TYPE = 3'd2,
      CSR_HEADER_BYTES     = 3'd3,
      CSR_DUPLICATE_WINDOW = 3'd4,
      CSR_IDLE_TIMEOUT_MS  = 3'd5
   } apsc_csr_index_type;

   // Register reset values
   localparam logic [31:0] MAGIC_RESET   = 32'd0;
   localparam logic [7:0]  VERSION_RESET = 8'd1;
   localparam logic [7:0]  STOP_RESET    = 8'd1;
   localparam logic [7:0]  HEADER_RESET  = 8'd32;
   localparam logic [15:0] WINDOW_RESET  = 16'd500;
   localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

   // Required audio format
   localparam logic [7:0]  REQ_CHANNELS    = 8'd2;
   localparam logic [7:0]  REQ_SAMPLE_BITS = 8'd16;
   localparam logic [31:0] REQ_SAMPLE_RATE = 32'd44100;

   typedef enum logic {
      OP_DATAGRAM = 1'b0,
      OP_TICK     = 1'b1
   } apsc_op_type;

   typedef enum logic [1:0] {
      ACT_TICK      = 2'd0,
      ACT_MALFORMED = 2'd1,
      ACT_STOPPED   = 2'd2,
      ACT_ACCEPTED  = 2'd3
   } apsc_action_type;

   typedef enum logic [2:0] {
      CLS_FIRST     = 3'd0,
      CLS_IN_ORDER  = 3'd1,
      CLS_DUPLICATE = 3'd2,
      CLS_OUT_ORDER = 3'd3,
      CLS_GAP       = 3'd4
   } apsc_class_type;

   typedef struct packed {
      logic        op;
      logic [31:0] now_ms;
      logic [15:0] datagram_bytes;
      logic [31:0] hdr_magic;
      logic [7:0]  hdr_version;
      logic [7:0]  hdr_type;
      logic [7:0]  hdr_channels;
      logic [7:0]  hdr_sample_bits;
      logic [31:0] hdr_sample_rate;
      logic [15:0] hdr_payload_bytes;
      logic [15:0] hdr_stream_id;
      logic [31:0] hdr_sequence;
   } apsc_req_type;

   typedef struct packed {
      apsc_action_type action;
      logic            flush_buffer;
      logic [15:0]     payload_to_write;
      apsc_class_type  sequence_class;
      logic            stream_active;
      logic [31:0]     received_count;
      logic [31:0]     lost_count;
      logic [31:0]     out_of_order_count;
      logic [31:0]     duplicate_count;
      logic [31:0]     malformed_count;
      logic [31:0]     next_expected;
   } apsc_rsp_type;

endpackage

[rtl/audio_packet_sequence_checker_top.sv]
// Audio packet sequence checker: header checks, stream tracking and loss counters.
//
//  port group  dir  handshake          payload
//  ----------  ---  -----------------  -----------------------------------
//  req_        in   req_valid/stall    apsc_req_type (datagram or tick)
//  rsp_        out  rsp_valid/stall    apsc_rsp_type (one per transfer)
//  csr_        in   csr_write          csr_index, csr_data (no read-back)
//
// One transfer per cycle sustained while rsp_stall is low. A request transfer
// lands in the input register; when it drains, its result is formed from the
// tracking state and loaded into the result register, which drives rsp_valid.
// The input register refills in the same cycle it drains, so rsp_stall only
// backs up into req_stall when both registers hold a transfer.
// Synchronous reset clears valids, tracking state and counters and loads the CSR reset values.
// The user must write registers only while no transfer is in flight; the block does not enforce it.
module audio_packet_sequence_checker_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  apsc_pkg::apsc_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output apsc_pkg::apsc_rsp_type               rsp_data,
   input  logic                                 csr_write,
   input  logic [apsc_pkg::CsrIndexBits-1:0]    csr_index,
   input  logic [apsc_pkg::CsrDataBits-1:0]     csr_data
);
   import apsc_pkg::*;

   // CSRs
   logic [31:0] magic_ff;
   logic [7:0]  version_ff;
   logic [7:0]  stop_type_ff;
   logic [7:0]  header_bytes_ff;
   logic [15:0] dup_window_ff;
   logic [15:0] idle_timeout_ff;

   // Input and result registers
   logic         s0_valid_ff;
   apsc_req_type s0_data_ff;
   logic         rsp_valid_ff;
   apsc_rsp_type rsp_data_ff;
   logic         take;
   logic         advance;

   // Tracking state
   logic        streaming_ff,     streaming_in;
   logic [15:0] stream_id_ff,     stream_id_in;
   logic [31:0] expected_ff,      expected_in;
   logic        first_ff,         first_in;
   logic [31:0] last_ms_ff,       last_ms_in;
   logic [31:0] cnt_received_ff,  cnt_received_in;
   logic [31:0] cnt_lost_ff,      cnt_lost_in;
   logic [31:0] cnt_ooo_ff,       cnt_ooo_in;
   logic [31:0] cnt_dup_ff,       cnt_dup_in;
   logic [31:0] cnt_malformed_ff, cnt_malformed_in;
   apsc_rsp_type rsp_data_in;

   // Datapath terms
   logic [31:0] idle_gap;
   logic        idle_expired;
   logic [16:0] len_sum;
   logic        bad_header;
   logic        bad_format;
   logic        new_stream;
   logic        is_first;
   logic [31:0] behind;
   logic [31:0] ahead;
   apsc_action_type act;
   apsc_class_type  cls;

   // Handshake: input register drains when the result register is free or draining
   assign advance   = s0_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s0_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            s0_valid_ff <= 1'b1;
         end else if (advance) begin
            s0_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s0_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff        <= MAGIC_RESET;
         version_ff      <= VERSION_RESET;
         stop_type_ff    <= STOP_RESET;
         header_bytes_ff <= HEADER_RESET;
         dup_window_ff   <= WINDOW_RESET;
         idle_timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write) begin
         case (apsc_csr_index_type'(csr_index))
            CSR_MAGIC_WORD:       magic_ff        <= csr_data[31:0];
            CSR_PROTOCOL_VERSION: version_ff      <= csr_data[7:0];
            CSR_STOP_PACKET_TYPE: stop_type_ff    <= csr_data[7:0];
            CSR_HEADER_BYTES:     header_bytes_ff <= csr_data[7:0];
            CSR_DUPLICATE_WINDOW: dup_window_ff   <= csr_data[15:0];
            CSR_IDLE_TIMEOUT_MS:  idle_timeout_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Checks and classification on the registered request
   assign idle_gap     = s0_data_ff.now_ms - last_ms_ff;
   assign idle_expired = idle_gap > {16'd0, idle_timeout_ff};
   // 17-bit sum: a length above 65535 never matches
   assign len_sum      = {9'd0, header_bytes_ff} + {1'b0, s0_data_ff.hdr_payload_bytes};
   assign bad_header   = (s0_data_ff.datagram_bytes < {8'd0, header_bytes_ff})
                      || (s0_data_ff.hdr_magic != magic_ff)
                      || (s0_data_ff.hdr_version != version_ff);
   assign bad_format   = (s0_data_ff.hdr_channels != REQ_CHANNELS)
                      || (s0_data_ff.hdr_sample_bits != REQ_SAMPLE_BITS)
                      || (s0_data_ff.hdr_sample_rate != REQ_SAMPLE_RATE)
                      || ({1'b0, s0_data_ff.datagram_bytes} != len_sum);
   assign new_stream   = !streaming_ff || (s0_data_ff.hdr_stream_id != stream_id_ff);
   assign is_first     = new_stream || first_ff;
   assign behind       = expected_ff - s0_data_ff.hdr_sequence;
   assign ahead        = s0_data_ff.hdr_sequence - expected_ff;

   always_comb begin
      streaming_in     = streaming_ff;
      stream_id_in     = stream_id_ff;
      expected_in      = expected_ff;
      first_in         = first_ff;
      last_ms_in       = last_ms_ff;
      cnt_received_in  = cnt_received_ff;
      cnt_lost_in      = cnt_lost_ff;
      cnt_ooo_in       = cnt_ooo_ff;
      cnt_dup_in       = cnt_dup_ff;
      cnt_malformed_in = cnt_malformed_ff;
      act              = ACT_TICK;
      cls              = CLS_FIRST;

      if (s0_data_ff.op == OP_TICK) begin
         if (streaming_ff && idle_expired) begin
            streaming_in = 1'b0;
         end
      end else if (bad_header) begin
         act              = ACT_MALFORMED;
         cnt_malformed_in = cnt_malformed_ff + 32'd1;
      end else if (s0_data_ff.hdr_type == stop_type_ff) begin
         act          = ACT_STOPPED;
         streaming_in = 1'b0;
      end else if (bad_format) begin
         act              = ACT_MALFORMED;
         cnt_malformed_in = cnt_malformed_ff + 32'd1;
      end else begin
         act             = ACT_ACCEPTED;
         streaming_in    = 1'b1;
         stream_id_in    = s0_data_ff.hdr_stream_id;
         first_in        = 1'b0;
         cnt_received_in = cnt_received_ff + 32'd1;
         last_ms_in      = s0_data_ff.now_ms;
         if (is_first) begin
            cls         = CLS_FIRST;
            expected_in = s0_data_ff.hdr_sequence + 32'd1;
         end else if (s0_data_ff.hdr_sequence == expected_ff) begin
            cls         = CLS_IN_ORDER;
            expected_in = expected_ff + 32'd1;
         end else if (s0_data_ff.hdr_sequence < expected_ff) begin
            // old packet: written but expected stays put
            if (behind < {16'd0, dup_window_ff}) begin
               cls        = CLS_DUPLICATE;
               cnt_dup_in = cnt_dup_ff + 32'd1;
            end else begin
               cls        = CLS_OUT_ORDER;
               cnt_ooo_in = cnt_ooo_ff + 32'd1;
            end
         end else begin
            cls         = CLS_GAP;
            cnt_lost_in = cnt_lost_ff + ahead;
            expected_in = s0_data_ff.hdr_sequence + 32'd1;
         end
      end

      rsp_data_in.action             = act;
      rsp_data_in.flush_buffer       = (act == ACT_STOPPED)
                                    || ((act == ACT_ACCEPTED) && new_stream);
      rsp_data_in.payload_to_write   = (act == ACT_ACCEPTED) ?
                                       s0_data_ff.hdr_payload_bytes : 16'd0;
      rsp_data_in.sequence_class     = cls;
      rsp_data_in.stream_active      = streaming_in;
      rsp_data_in.received_count     = cnt_received_in;
      rsp_data_in.lost_count         = cnt_lost_in;
      rsp_data_in.out_of_order_count = cnt_ooo_in;
      rsp_data_in.duplicate_count    = cnt_dup_in;
      rsp_data_in.malformed_count    = cnt_malformed_in;
      rsp_data_in.next_expected      = expected_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         streaming_ff     <= 1'b0;
         stream_id_ff     <= 16'd0;
         expected_ff      <= 32'd0;
         first_ff         <= 1'b1;
         last_ms_ff       <= 32'd0;
         cnt_received_ff  <= 32'd0;
         cnt_lost_ff      <= 32'd0;
         cnt_ooo_ff       <= 32'd0;
         cnt_dup_ff       <= 32'd0;
         cnt_malformed_ff <= 32'd0;
      end else if (advance) begin
         streaming_ff     <= streaming_in;
         stream_id_ff     <= stream_id_in;
         expected_ff      <= expected_in;
         first_ff         <= first_in;
         last_ms_ff       <= last_ms_in;
         cnt_received_ff  <= cnt_received_in;
         cnt_lost_ff      <= cnt_lost_in;
         cnt_ooo_ff       <= cnt_ooo_in;
         cnt_dup_ff       <= cnt_dup_in;
         cnt_malformed_ff <= cnt_malformed_in;
      end
   end

   // Assertions
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s0_valid_ff)
      else $error("req_stall with empty input register");

   a_accept_counts: assert property (@(posedge clock) disable iff (reset)
      (advance && act == ACT_ACCEPTED) |=>
         cnt_received_ff == $past(cnt_received_ff) + 32'd1)
      else $error("accepted datagram not counted");

   a_accept_streams: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.action == ACT_ACCEPTED) |-> rsp_data_ff.stream_active)
      else $error("accepted datagram without streaming");

   a_flush_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.flush_buffer && rsp_data_ff.action == ACT_ACCEPTED)
         |-> rsp_data_ff.sequence_class == CLS_FIRST)
      else $error("new-stream flush not classed first");

   a_stop_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.action == ACT_STOPPED)
         |-> (!rsp_data_ff.stream_active && rsp_data_ff.payload_to_write == 16'd0))
      else $error("stop result still streaming or writing");

endmodule
